FILE: sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Holds the request and result beat structs and the controller/datapath interface.
// No dependencies.
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ITEM_WIDTH_DEF  = 32;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Word index of the direction register on the configuration port.
    localparam logic REG_ORDER = 1'b0;

    typedef enum logic [1:0] {
        REQ_PUT    = 2'd0,
        REQ_GET    = 2'd1,
        REQ_COUNT  = 2'd2,
        REQ_REMOVE = 2'd3
    } t_req_code;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_req_code            req_type;
        logic [VALUE_W-1:0]   item_value;
    } t_req_beat;

    typedef struct packed {
        logic [VALUE_W-1:0]   head_value;
        t_status              status;
        logic [COUNT_W-1:0]   match_count;
        logic                 queue_empty;
        logic [COUNT_W-1:0]   occupancy;
    } t_result_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    insert;
        logic    pop;
        logic    remove_step;
        logic    mask_load;
        logic    mask_step;
        logic    status_we;
        t_status status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic any_match;
        logic mask_zero;
    } t_dp_stat;

endpackage

FILE: sv/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: configuration port, controller and datapath.
// Depends on spq_pkg, spq_ctrl and spq_dpath.
//
//   Channel   Signals                         Moves
//   request   start, busy, i_req              one request beat when start && !busy
//   result    o_done, o_result                one result beat per request, one cycle
//   config    psel/penable/pwrite/paddr/...   APB writes and reads of the direction bit
//
// Put and get first shift the cell row and then show the result in the response state,
// in which the next request may already be taken.
// Count and remove run on for each matching item, because the match mask and the gap
// closing retire one matching item per cycle.
// Reset empties the queue and selects ascending order; no clearing pass is needed.
// The result is shown for exactly one cycle and is not held; the receiver cannot stall.
module sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int ITEM_WIDTH  = spq_pkg::ITEM_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel.
    input  logic                          start,
    output logic                          busy,
    input  spq_pkg::t_req_beat            i_req,
    // Result channel.
    output logic                          o_done,
    output spq_pkg::t_result_beat         o_result,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spq_pkg::PADDR_W-1:0]   paddr,
    input  logic [spq_pkg::PDATA_W-1:0]   pwdata,
    output logic [spq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic              r_order_desc;
    logic              w_cfg_write;
    spq_pkg::t_dp_cmd  w_cmd;
    spq_pkg::t_dp_stat w_stat;

    // The port never inserts wait states. The register word index is paddr[2];
    // byte lanes within a word are ignored.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_desc <= 1'b0;
        end else if (w_cfg_write && paddr[2] == spq_pkg::REG_ORDER) begin
            r_order_desc <= pwdata[0];
        end
    end

    // Reads return the direction bit for its word and zero for any other word.
    always_comb begin
        prdata = '0;
        if (paddr[2] == spq_pkg::REG_ORDER) begin
            prdata[0] = r_order_desc;
        end
    end

    // The controller sequences each request; the datapath holds the sorted cells,
    // the fill count and the result fields, which stay put while the result is shown.
    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_stat     (w_stat),
        .o_busy     (busy),
        .o_done     (o_done),
        .o_cmd      (w_cmd)
    );

    spq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ITEM_WIDTH  (ITEM_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_order_desc (r_order_desc),
        .i_item_value (i_req.item_value),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_result     (o_result)
    );

endmodule

FILE: sv/spq_dpath.sv
// Datapath of the sorted priority queue: the row of item cells, the fill count,
// the match mask and the result registers. Depends on spq_pkg.
module spq_dpath #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int ITEM_WIDTH  = spq_pkg::ITEM_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_order_desc,
    input  logic [spq_pkg::VALUE_W-1:0] i_item_value,
    input  spq_pkg::t_dp_cmd        i_cmd,
    output spq_pkg::t_dp_stat       o_stat,
    output spq_pkg::t_result_beat   o_result
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [ITEM_WIDTH-1:0]  r_cell [QUEUE_DEPTH];
    logic [ITEM_WIDTH-1:0]  n_cell [QUEUE_DEPTH];
    logic [CW-1:0]          r_count, n_count;
    logic [ITEM_WIDTH-1:0]  r_item;
    logic [ITEM_WIDTH-1:0]  r_head;
    spq_pkg::t_status       r_status;
    logic [CW-1:0]          r_mcnt;
    logic [QUEUE_DEPTH-1:0] r_mask;

    logic [QUEUE_DEPTH-1:0] w_match;
    logic [QUEUE_DEPTH-1:0] w_place;
    logic [QUEUE_DEPTH-1:0] w_place_from;
    logic [QUEUE_DEPTH-1:0] w_match_from;

    // Per-cell compares. A cell past the fill count counts as a place where a
    // new item may go, so the insertion point always exists when not full.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            logic valid;
            logic precedes;
            valid    = CW'(i) < r_count;
            precedes = i_order_desc ? (r_item > r_cell[i]) : (r_item < r_cell[i]);
            w_match[i] = valid && (r_cell[i] == r_item);
            w_place[i] = !valid || precedes;
        end
    end

    // All bits from the lowest set bit upward.
    assign w_place_from = ~((w_place - QUEUE_DEPTH'(1)) & ~w_place);
    assign w_match_from = ~((w_match - QUEUE_DEPTH'(1)) & ~w_match);

    always_comb begin
        n_count = r_count;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            logic [ITEM_WIDTH-1:0] above;
            logic [ITEM_WIDTH-1:0] below;
            above = (i < QUEUE_DEPTH - 1) ? r_cell[(i + 1) % QUEUE_DEPTH] : r_cell[i];
            below = (i > 0) ? r_cell[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH] : r_cell[i];
            n_cell[i] = r_cell[i];
            if (i_cmd.insert) begin
                if (i > 0 && w_place_from[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]) begin
                    n_cell[i] = below;
                end else if (w_place_from[i]) begin
                    n_cell[i] = r_item;
                end
            end else if (i_cmd.pop) begin
                n_cell[i] = above;
            end else if (i_cmd.remove_step && w_match_from[i]) begin
                n_cell[i] = above;
            end
        end
        if (i_cmd.insert) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop || i_cmd.remove_step) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (i_cmd.load) begin
            r_item   <= ITEM_WIDTH'(i_item_value);
            r_head   <= '0;
            r_status <= spq_pkg::ST_OK;
            r_mcnt   <= '0;
        end
        if (i_cmd.pop) begin
            r_head <= r_cell[0];
        end
        if (i_cmd.status_we) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.mask_load) begin
            r_mask <= w_match;
        end else if (i_cmd.mask_step) begin
            r_mask <= r_mask & (r_mask - QUEUE_DEPTH'(1));
            r_mcnt <= r_mcnt + CW'(1);
        end
    end

    assign o_stat.full      = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.any_match = |w_match;
    assign o_stat.mask_zero = (r_mask == '0);

    assign o_result.head_value  = spq_pkg::VALUE_W'(r_head);
    assign o_result.status      = r_status;
    assign o_result.match_count = spq_pkg::COUNT_W'(r_mcnt);
    assign o_result.queue_empty = (r_count == '0);
    assign o_result.occupancy   = spq_pkg::COUNT_W'(r_count);

endmodule

FILE: sv/spq_ctrl.sv
// Controller of the sorted priority queue: request handshake and sequencing
// of the datapath steps for each request kind. Depends on spq_pkg.
module spq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  spq_pkg::t_req_code  i_req_type,
    input  spq_pkg::t_dp_stat   i_stat,
    output logic                o_busy,
    output logic                o_done,
    output spq_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_PUT      = 7'b0000010,
        S_GET      = 7'b0000100,
        S_CNT_LOAD = 7'b0001000,
        S_CNT      = 7'b0010000,
        S_REM      = 7'b0100000,
        S_RESP     = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_busy   = !(r_state == S_IDLE || r_state == S_RESP);
    assign o_done   = (r_state == S_RESP);
    assign w_accept = i_start && !o_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = spq_pkg::ST_OK;
        unique case (r_state)
            S_IDLE, S_RESP: begin
                n_state = S_IDLE;
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    unique case (i_req_type)
                        spq_pkg::REQ_PUT:    n_state = S_PUT;
                        spq_pkg::REQ_GET:    n_state = S_GET;
                        spq_pkg::REQ_COUNT:  n_state = S_CNT_LOAD;
                        spq_pkg::REQ_REMOVE: n_state = S_REM;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_PUT: begin
                if (i_stat.full) begin
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = spq_pkg::ST_FULL;
                end else begin
                    o_cmd.insert = 1'b1;
                end
                n_state = S_RESP;
            end
            S_GET: begin
                if (i_stat.empty) begin
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = spq_pkg::ST_EMPTY;
                end else begin
                    o_cmd.pop = 1'b1;
                end
                n_state = S_RESP;
            end
            S_CNT_LOAD: begin
                o_cmd.mask_load = 1'b1;
                n_state = S_CNT;
            end
            S_CNT: begin
                if (i_stat.mask_zero) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.mask_step = 1'b1;
                end
            end
            S_REM: begin
                if (i_stat.any_match) begin
                    o_cmd.remove_step = 1'b1;
                end else begin
                    n_state = S_RESP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for sorted_priority_queue_core.
// Drives request beats and APB direction writes, predicts every result beat in a
// scoreboard class and checks it field by field. Depends on spq_pkg and the core.
`timescale 1ns / 100ps

module tb;
    import spq_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 300;
    localparam int PHASE_COUNT  = 6;
    localparam int CHUNK_ITEMS  = 40;
    localparam int DRAIN_CYCLES = 24;

    // Request mix used for one chunk of the random part.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    // Scoreboard: a private copy of the sorted cell row and the direction bit,
    // plus the result beats that accepted requests still owe.
    class sorted_queue_checker;
        logic [VALUE_W-1:0] cells[$];
        bit                 descending;
        t_result_beat       owed_results[$];
        int                 errors;

        function new();
            descending = 1'b0;
            errors     = 0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Work out what the block must answer for one request and update the copy.
        function t_result_beat predict_result(t_req_beat req);
            t_result_beat       res;
            logic [VALUE_W-1:0] kept[$];
            int                 pos;
            int                 hits;
            res  = '0;
            hits = 0;
            res.status = ST_OK;
            case (req.req_type)
                REQ_PUT: begin
                    if (cells.size() >= QUEUE_DEPTH_DEF) begin
                        res.status = ST_FULL;
                    end else begin
                        // The new item goes in front of the first cell that it must
                        // precede, so it lands behind every equal item.
                        pos = 0;
                        while (pos < cells.size() &&
                               !(descending ? (req.item_value > cells[pos])
                                            : (req.item_value < cells[pos])))
                            pos++;
                        cells.insert(pos, req.item_value);
                    end
                end
                REQ_GET: begin
                    if (cells.size() == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.head_value = cells.pop_front();
                    end
                end
                REQ_COUNT: begin
                    foreach (cells[i])
                        if (cells[i] == req.item_value) hits++;
                    res.match_count = COUNT_W'(hits);
                end
                default: begin
                    foreach (cells[i])
                        if (cells[i] != req.item_value) kept.push_back(cells[i]);
                    cells = kept;
                end
            endcase
            res.queue_empty = (cells.size() == 0);
            res.occupancy   = COUNT_W'(cells.size());
            return res;
        endfunction

        function void note_request(t_req_beat req);
            owed_results.push_back(predict_result(req));
        endfunction

        task compare_field(string name, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_result(t_result_beat got);
            t_result_beat want;
            if (owed_results.size() == 0) begin
                report("result beat with no request outstanding");
            end else begin
                want = owed_results.pop_front();
                compare_field("head_value", got.head_value, want.head_value);
                compare_field("status", VALUE_W'(got.status), VALUE_W'(want.status));
                compare_field("match_count", VALUE_W'(got.match_count),
                              VALUE_W'(want.match_count));
                compare_field("queue_empty", VALUE_W'(got.queue_empty),
                              VALUE_W'(want.queue_empty));
                compare_field("occupancy", VALUE_W'(got.occupancy),
                              VALUE_W'(want.occupancy));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_req_beat          i_req;
    logic               o_done;
    t_result_beat       o_result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    sorted_queue_checker sb = new();

    // When set, the sender inserts random gaps between request beats.
    bit                 gaps_on;
    // Values reused within a phase so that duplicates, counts and removes hit.
    logic [VALUE_W-1:0] value_pool[4];

    sorted_priority_queue_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The result channel cannot be stalled, so every strobed beat is checked at
    // the rising edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            sb.check_result(o_result);
        end
    end

    // Watchdog: any accepted request beat, result beat or APB access counts as
    // progress. A long run of cycles without any of them ends the test.
    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1 ||
                (psel === 1'b1 && penable === 1'b1))
                stall = 0;
            else
                stall++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Present one request beat from the falling edge on and hold it until the
    // block takes it. Start stays high afterwards so back-to-back beats follow with no
    // gap; this task lowers it before a random gap, and wait_idle before an idle period.
    task send_request(t_req_code code, logic [VALUE_W-1:0] value);
        t_req_beat beat;
        beat.req_type   = code;
        beat.item_value = value;
        @(negedge i_clk);
        start = 1'b1;
        i_req = beat;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(beat);
        if (gaps_on && $urandom_range(99) < 6) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(7)) @(negedge i_clk);
        end
    endtask

    // Lower start and wait until every owed result beat has come back, plus a
    // short margin, so that the direction register is written while idle.
    task wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write of the direction bit followed by a read back of the register.
    task set_order(bit desc);
        logic [PDATA_W-1:0] readback;
        wait_idle();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(REG_ORDER) << 2;
        pwdata  = {$urandom() & ~PDATA_W'(1)} | PDATA_W'(desc);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.descending = desc;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        readback = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== PDATA_W'(desc))
            sb.report($sformatf("direction read back 0x%0h, expected %0d", readback, desc));
    endtask

    // Pick an item or a probe. Counts and removes mostly probe a value that is
    // currently stored so that matches, including runs of duplicates, are common.
    function logic [VALUE_W-1:0] pick_value(t_req_code code);
        if ((code == REQ_COUNT || code == REQ_REMOVE) && sb.cells.size() != 0 &&
            $urandom_range(99) < 60)
            return sb.cells[$urandom_range(sb.cells.size() - 1)];
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4, 5: return value_pool[$urandom_range(3)];
            default: return $urandom();
        endcase
    endfunction

    function t_req_code pick_code(t_mix mix);
        int roll;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL:  return roll < 70 ? REQ_PUT : roll < 80 ? REQ_GET :
                              roll < 90 ? REQ_COUNT : REQ_REMOVE;
            MIX_DRAIN: return roll < 15 ? REQ_PUT : roll < 85 ? REQ_GET :
                              roll < 95 ? REQ_COUNT : REQ_REMOVE;
            default:   return t_req_code'(roll % 4);
        endcase
    endfunction

    initial begin
        t_mix      mix;
        t_req_code code;
        bit        desc;
        start   = 1'b0;
        i_req   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        gaps_on = 1'b0;
        i_rst_n = 1'b0;
        mix     = MIX_EVEN;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, ascending order: a get on an empty queue, both extreme
        // values, a pair of equal items, counts and removes with and without a
        // match, and the queue drained back to empty.
        set_order(1'b0);
        send_request(REQ_GET, 32'd0);
        send_request(REQ_PUT, '1);
        send_request(REQ_PUT, '0);
        send_request(REQ_PUT, 32'd5);
        send_request(REQ_PUT, 32'd5);
        send_request(REQ_COUNT, 32'd5);
        send_request(REQ_COUNT, 32'd7);
        send_request(REQ_REMOVE, 32'd7);
        send_request(REQ_REMOVE, 32'd5);
        send_request(REQ_GET, 32'd0);
        send_request(REQ_GET, 32'd0);
        send_request(REQ_GET, 32'd0);

        // Descending order, then a switch back to ascending while items are still
        // stored: the old row is not re-sorted and new puts scan from the head.
        set_order(1'b1);
        send_request(REQ_PUT, 32'd3);
        send_request(REQ_PUT, 32'd9);
        send_request(REQ_PUT, '0);
        send_request(REQ_PUT, '1);
        send_request(REQ_COUNT, 32'd9);
        send_request(REQ_GET, 32'd0);
        set_order(1'b0);
        send_request(REQ_PUT, 32'd4);
        send_request(REQ_PUT, 32'd8);
        send_request(REQ_GET, 32'd0);
        send_request(REQ_GET, 32'd0);

        // Random part. Each phase picks a direction (both extremes are forced
        // early), keeps whatever the queue holds, and runs chunks with a fill,
        // drain or even mix so that full and empty queues both come up often.
        // The second phase runs without any sender gaps.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            desc = (phase < 2) ? bit'(phase) : bit'($urandom_range(1));
            set_order(desc);
            gaps_on = (phase != 1);
            foreach (value_pool[k])
                value_pool[k] = ($urandom_range(1) != 0) ? VALUE_W'($urandom_range(15))
                                                         : VALUE_W'($urandom());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % CHUNK_ITEMS == 0)
                    mix = t_mix'($urandom_range(2));
                code = pick_code(mix);
                send_request(code, pick_value(code));
            end
        end

        // Wait for every owed result, then a little longer to catch stray beats.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.owed_results.size() != 0)
            sb.report($sformatf("%0d result beats never arrived", sb.owed_results.size()));
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
